### hdl/qmpat_pkg.sv
package qmpat_pkg;

   // Table geometry.
   localparam int SLOTS = 48;
   localparam int Q     = 32;
   localparam int BASE  = (SLOTS > Q) ? (SLOTS - Q) : 1;
   localparam int AW    = $clog2(SLOTS);
   localparam int FI_W  = $clog2(SLOTS + 1);

   // Serial divider widths: a 50-bit scaled sum shifted by 16 over a 48-bit divisor.
   localparam int DIV_N  = 66;
   localparam int DIV_D  = 48;
   localparam int DIV_CW = $clog2(DIV_N + 1);

   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] M32 = 32'hFFFF_FFFF;
   localparam logic [16:0] ONE = 17'h1_0000;

   // Result status codes.
   typedef logic [2:0] status_type;
   localparam status_type ST_UPDATED  = 3'd0;
   localparam status_type ST_DROPPED  = 3'd1;
   localparam status_type ST_INSERTED = 3'd2;
   localparam status_type ST_INS_SEL  = 3'd3;
   localparam status_type ST_READOUT  = 3'd4;

   // One table slot.
   typedef struct packed {
      logic [31:0] key;
      logic [47:0] adj;
      logic [31:0] wgt;
      logic [16:0] ratio;
      logic [15:0] draw;
      logic [47:0] prio;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [DIV_N-1:0] dividend;
      logic [DIV_D-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_N-1:0] quotient;
   } div_rsp_type;

   // Low six bits of a slot index.
   function automatic logic [5:0] slot6(input logic [7:0] idx);
      return idx[5:0];
   endfunction

endpackage

### hdl/qmpat_div.sv
module qmpat_div
   import qmpat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_D-1:0]  rem_ff;
   logic [DIV_N-1:0]  quo_ff;
   logic [DIV_D-1:0]  dvs_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIV_D:0]    trial;
   logic [DIV_D:0]    diff;
   logic              ge;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   // One quotient bit per cycle, done pulses after the last bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CW'(DIV_N);
            rem_ff  <= '0;
            quo_ff  <= div_req.dividend;
            dvs_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
            quo_ff <= {quo_ff[DIV_N-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### hdl/qmax_priority_aggregation_table.sv
// Channel  Direction  Handshake             Beat
// req      in         req_valid/req_ready   command, key, weight, draw
// rsp      out        rsp_valid/rsp_ready   status, slot, entry fields, threshold, discard
//
// An insert scans the live slots one by one, then spends up to three serial
// divisions in the shared divider. A selection runs a quickselect over the slot
// memory, exchanging slots by two reads and two writes through the single port.
// A read streams min(Q, SLOTS-1) beats and pauses while rsp is stalled. Reset
// empties the table at once through per-slot valid bits.
// The result register holds a finished beat while the sequencer moves on.
module qmax_priority_aggregation_table
   import qmpat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_item_key,
   input  logic [15:0] req_item_weight,
   input  logic [15:0] req_uniform_draw,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_entry_key,
   output logic [47:0] rsp_entry_adjusted,
   output logic [31:0] rsp_entry_weight,
   output logic [16:0] rsp_entry_ratio,
   output logic [47:0] rsp_threshold,
   output logic [47:0] rsp_discard_max,
   output logic        rsp_last
);

   typedef enum logic [27:0] {
      S_IDLE     = 28'h0000001,
      S_SR_TEST  = 28'h0000002,
      S_SR_CMP   = 28'h0000004,
      S_U_MUL    = 28'h0000008,
      S_U_SUM    = 28'h0000010,
      S_U_DIVR   = 28'h0000020,
      S_U_Q      = 28'h0000040,
      S_U_DIVA   = 28'h0000080,
      S_U_ADD    = 28'h0000100,
      S_U_DIVP   = 28'h0000200,
      S_U_WR     = 28'h0000400,
      S_I_PRIO   = 28'h0000800,
      S_I_DIVP   = 28'h0001000,
      S_I_CHK    = 28'h0002000,
      S_I_OLD    = 28'h0004000,
      S_EMIT     = 28'h0008000,
      S_SEL_TEST = 28'h0010000,
      S_SEL_PIV  = 28'h0020000,
      S_SEL_LOOP = 28'h0040000,
      S_SEL_CMP  = 28'h0080000,
      S_SEL_DONE = 28'h0100000,
      S_SEL_THR  = 28'h0200000,
      S_SW_A     = 28'h0400000,
      S_SW_B     = 28'h0800000,
      S_SW_C     = 28'h1000000,
      S_SW_D     = 28'h2000000,
      S_RO_RD    = 28'h4000000,
      S_RO_OUT   = 28'h8000000
   } state_type;

   // Control state.
   state_type         state_ff, state_in;
   logic [FI_W-1:0]   fi_ff, fi_in;
   logic [47:0]       thr_ff, thr_in;
   logic [47:0]       dp_ff, dp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOTS-1:0]  valid_ff;

   // Working payload.
   logic [31:0]       key_ff, key_in;
   logic [15:0]       x_ff, x_in;
   logic [15:0]       u_ff, u_in;
   logic [FI_W-1:0]   sidx_ff, sidx_in;
   entry_type         ent_ff, ent_in;
   logic [FI_W-1:0]   slot_ff, slot_in;
   status_type        status_ff, status_in;
   logic [48:0]       p1_ff, p1_in;
   logic [32:0]       p2_ff, p2_in;
   logic [49:0]       a1_ff, a1_in;
   logic [16:0]       q_ff, q_in;
   logic [FI_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, np_ff, np_in, it_ff, it_in;
   logic [47:0]       pv_ff, pv_in;
   logic [AW-1:0]     sa_ff, sa_in, sb_ff, sb_in;
   entry_type         tmp_ff, tmp_in;
   state_type         ret_ff, ret_in;
   logic              sel_rd_ff, sel_rd_in;

   // Result register.
   status_type        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_slot_ff, rsp_slot_in;
   entry_type         rsp_ent_ff, rsp_ent_in;
   logic [47:0]       rsp_thr_ff, rsp_thr_in;
   logic [47:0]       rsp_dp_ff, rsp_dp_in;
   logic              rsp_last_ff, rsp_last_in;

   // Slot memory port.
   entry_type         mem [SLOTS];
   entry_type         rd_data_ff;
   logic              rd_vld_ff;
   entry_type         rd_ent;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   entry_type         wr_data;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              out_free;
   logic [48:0]       sum_a;
   logic [32:0]       sum_w;
   logic [31:0]       w_sat;
   logic [FI_W-1:0]   fi_new;

   qmpat_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A slot never written reads as a cleared entry.
   assign rd_ent   = rd_vld_ff ? rd_data_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Saturating accumulation of the item into the working entry.
   always_comb begin
      sum_a = 49'(ent_ff.adj) + 49'({x_ff, 16'h0000});
      sum_w = 33'(ent_ff.wgt) + 33'(x_ff);
      w_sat = sum_w[32] ? M32 : sum_w[31:0];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      fi_in         = fi_ff;
      thr_in        = thr_ff;
      dp_in         = dp_ff;
      key_in        = key_ff;
      x_in          = x_ff;
      u_in          = u_ff;
      sidx_in       = sidx_ff;
      ent_in        = ent_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      a1_in         = a1_ff;
      q_in          = q_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      np_in         = np_ff;
      it_in         = it_ff;
      pv_in         = pv_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      tmp_in        = tmp_ff;
      ret_in        = ret_ff;
      sel_rd_in     = sel_rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_dp_in     = rsp_dp_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = ent_ff;
      div_req       = '0;
      fi_new        = (fi_ff == '0 || fi_ff > FI_W'(SLOTS)) ? FI_W'(BASE) : fi_ff;
      fi_new        = fi_new - 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in = req_item_key;
               x_in   = req_item_weight;
               u_in   = req_uniform_draw;
               if (req_command) begin
                  sel_rd_in = 1'b1;
                  lo_in     = '0;
                  hi_in     = FI_W'(SLOTS - 1);
                  state_in  = S_SEL_TEST;
               end else begin
                  sidx_in  = fi_ff;
                  state_in = S_SR_TEST;
               end
            end
         end

         // Scan the live slots for the key.
         S_SR_TEST: begin
            if (sidx_ff < FI_W'(SLOTS)) begin
               rd_en    = 1'b1;
               rd_addr  = sidx_ff[AW-1:0];
               state_in = S_SR_CMP;
            end else begin
               state_in = S_I_PRIO;
            end
         end
         S_SR_CMP: begin
            if (rd_ent.key == key_ff) begin
               ent_in   = rd_ent;
               slot_in  = sidx_ff;
               state_in = S_U_MUL;
            end else begin
               sidx_in  = sidx_ff + 1'b1;
               state_in = S_SR_TEST;
            end
         end

         // Update in place: scale the sum by the ratio.
         S_U_MUL: begin
            p1_in    = 49'(ent_ff.adj[47:16]) * 49'(ent_ff.ratio);
            p2_in    = 33'(ent_ff.adj[15:0]) * 33'(ent_ff.ratio);
            state_in = S_U_SUM;
         end
         S_U_SUM: begin
            a1_in = 50'(p1_ff) + 50'(p2_ff[32:16]);
            q_in  = ent_ff.ratio;
            if (dp_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N'({ent_ff.wgt, 16'h0000});
               div_req.divisor  = dp_ff;
               state_in         = S_U_DIVR;
            end else begin
               state_in = S_U_Q;
            end
         end
         // Lower the ratio to weight over discard peak.
         S_U_DIVR: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient < DIV_N'(q_ff)) begin
                  q_in = div_rsp.quotient[16:0];
               end
               state_in = S_U_Q;
            end
         end
         S_U_Q: begin
            if (q_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = {a1_ff, 16'h0000};
               div_req.divisor  = DIV_D'(q_ff);
               state_in         = S_U_DIVA;
            end else begin
               ent_in.adj = (a1_ff > 50'(M48)) ? M48 : a1_ff[47:0];
               state_in   = S_U_ADD;
            end
         end
         // Divide the sum back by the new ratio.
         S_U_DIVA: begin
            if (div_rsp.done) begin
               ent_in.adj = (div_rsp.quotient > DIV_N'(M48)) ? M48 :
                            div_rsp.quotient[47:0];
               state_in   = S_U_ADD;
            end
         end
         S_U_ADD: begin
            ent_in.adj   = sum_a[48] ? M48 : sum_a[47:0];
            ent_in.wgt   = w_sat;
            ent_in.ratio = q_ff;
            if (ent_ff.draw == '0) begin
               ent_in.prio = M48;
               state_in    = S_U_WR;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N'({w_sat, 16'h0000});
               div_req.divisor  = DIV_D'(ent_ff.draw);
               state_in         = S_U_DIVP;
            end
         end
         S_U_DIVP: begin
            if (div_rsp.done) begin
               ent_in.prio = div_rsp.quotient[47:0];
               state_in    = S_U_WR;
            end
         end
         S_U_WR: begin
            wr_en     = 1'b1;
            wr_addr   = slot_ff[AW-1:0];
            status_in = ST_UPDATED;
            state_in  = S_EMIT;
         end

         // New key: priority of the arriving item.
         S_I_PRIO: begin
            ent_in.key   = key_ff;
            ent_in.adj   = 48'({x_ff, 16'h0000});
            ent_in.wgt   = 32'(x_ff);
            ent_in.ratio = ONE;
            ent_in.draw  = u_ff;
            if (u_ff == '0) begin
               ent_in.prio = M48;
               state_in    = S_I_CHK;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N'({x_ff, 16'h0000});
               div_req.divisor  = DIV_D'(u_ff);
               state_in         = S_I_DIVP;
            end
         end
         S_I_DIVP: begin
            if (div_rsp.done) begin
               ent_in.prio = div_rsp.quotient[47:0];
               state_in    = S_I_CHK;
            end
         end
         S_I_CHK: begin
            if (ent_ff.prio < thr_ff) begin
               if (ent_ff.prio > dp_ff) begin
                  dp_in = ent_ff.prio;
               end
               status_in = ST_DROPPED;
               slot_in   = '0;
               state_in  = S_EMIT;
            end else begin
               fi_in    = fi_new;
               slot_in  = fi_new;
               rd_en    = 1'b1;
               rd_addr  = fi_new[AW-1:0];
               state_in = S_I_OLD;
            end
         end
         // The displaced priority raises the discard peak.
         S_I_OLD: begin
            if (rd_ent.prio > dp_ff) begin
               dp_in = rd_ent.prio;
            end
            wr_en   = 1'b1;
            wr_addr = slot_ff[AW-1:0];
            if (fi_ff != '0) begin
               status_in = ST_INSERTED;
               state_in  = S_EMIT;
            end else begin
               status_in = ST_INS_SEL;
               slot_in   = '0;
               sel_rd_in = 1'b0;
               lo_in     = '0;
               hi_in     = FI_W'(SLOTS - 1);
               state_in  = S_SEL_TEST;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot6(8'(slot_ff));
               rsp_ent_in    = ent_ff;
               rsp_thr_in    = thr_ff;
               rsp_dp_in     = dp_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // Quickselect: one partition per pass over lo..hi.
         S_SEL_TEST: begin
            if (lo_ff <= hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff[AW-1:0];
               state_in = S_SEL_PIV;
            end else begin
               fi_in    = FI_W'(BASE);
               sidx_in  = FI_W'(BASE);
               state_in = sel_rd_ff ? S_RO_RD : S_EMIT;
            end
         end
         S_SEL_PIV: begin
            pv_in    = rd_ent.prio;
            np_in    = hi_ff;
            it_in    = hi_ff;
            sa_in    = lo_ff[AW-1:0];
            sb_in    = hi_ff[AW-1:0];
            ret_in   = S_SEL_LOOP;
            state_in = S_SW_A;
         end
         S_SEL_LOOP: begin
            if (it_ff > lo_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(it_ff - 1'b1);
               state_in = S_SEL_CMP;
            end else begin
               sa_in    = hi_ff[AW-1:0];
               sb_in    = np_ff[AW-1:0];
               ret_in   = S_SEL_DONE;
               state_in = S_SW_A;
            end
         end
         // Larger priorities collect at the top end.
         S_SEL_CMP: begin
            it_in = it_ff - 1'b1;
            if (rd_ent.prio > pv_ff) begin
               np_in    = np_ff - 1'b1;
               sa_in    = AW'(it_ff - 1'b1);
               sb_in    = AW'(np_ff - 1'b1);
               ret_in   = S_SEL_LOOP;
               state_in = S_SW_A;
            end else begin
               state_in = S_SEL_LOOP;
            end
         end
         S_SEL_DONE: begin
            if (np_ff == FI_W'(BASE)) begin
               rd_en    = 1'b1;
               rd_addr  = np_ff[AW-1:0];
               state_in = S_SEL_THR;
            end else begin
               if (np_ff > FI_W'(BASE)) begin
                  hi_in = np_ff - 1'b1;
               end else begin
                  lo_in = np_ff + 1'b1;
               end
               state_in = S_SEL_TEST;
            end
         end
         S_SEL_THR: begin
            thr_in   = rd_ent.prio;
            fi_in    = FI_W'(BASE);
            sidx_in  = FI_W'(BASE);
            state_in = sel_rd_ff ? S_RO_RD : S_EMIT;
         end

         // Exchange of two slots through the single read and write port.
         S_SW_A: begin
            rd_en    = 1'b1;
            rd_addr  = sa_ff;
            state_in = S_SW_B;
         end
         S_SW_B: begin
            tmp_in   = rd_ent;
            rd_en    = 1'b1;
            rd_addr  = sb_ff;
            state_in = S_SW_C;
         end
         S_SW_C: begin
            wr_en    = 1'b1;
            wr_addr  = sa_ff;
            wr_data  = rd_ent;
            state_in = S_SW_D;
         end
         S_SW_D: begin
            wr_en    = 1'b1;
            wr_addr  = sb_ff;
            wr_data  = tmp_ff;
            state_in = ret_ff;
         end

         // Stream slots BASE..SLOTS-1.
         S_RO_RD: begin
            rd_en    = 1'b1;
            rd_addr  = sidx_ff[AW-1:0];
            state_in = S_RO_OUT;
         end
         S_RO_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_READOUT;
               rsp_slot_in   = slot6(8'(sidx_ff));
               rsp_ent_in    = rd_ent;
               rsp_thr_in    = thr_ff;
               rsp_dp_in     = dp_ff;
               rsp_last_in   = (sidx_ff == FI_W'(SLOTS - 1));
               if (sidx_ff == FI_W'(SLOTS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  sidx_in  = sidx_ff + 1'b1;
                  state_in = S_RO_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Slot memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fi_ff        <= FI_W'(SLOTS);
         thr_ff       <= '0;
         dp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         fi_ff        <= fi_in;
         thr_ff       <= thr_in;
         dp_ff        <= dp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      x_ff          <= x_in;
      u_ff          <= u_in;
      sidx_ff       <= sidx_in;
      ent_ff        <= ent_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      a1_ff         <= a1_in;
      q_ff          <= q_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      np_ff         <= np_in;
      it_ff         <= it_in;
      pv_ff         <= pv_in;
      sa_ff         <= sa_in;
      sb_ff         <= sb_in;
      tmp_ff        <= tmp_in;
      ret_ff        <= ret_in;
      sel_rd_ff     <= sel_rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_thr_ff    <= rsp_thr_in;
      rsp_dp_ff     <= rsp_dp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_entry_key      = rsp_ent_ff.key;
   assign rsp_entry_adjusted = rsp_ent_ff.adj;
   assign rsp_entry_weight   = rsp_ent_ff.wgt;
   assign rsp_entry_ratio    = rsp_ent_ff.ratio;
   assign rsp_threshold      = rsp_thr_ff;
   assign rsp_discard_max    = rsp_dp_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
